### design/b64e_pkg.sv
// Shared types, constants and the character table of the base64 line encoder.
package b64e_pkg;

    // Configuration register map (index in words, byte address = 4 * index)
    localparam int unsigned ApbAddrW      = 3;
    localparam logic        RegLineGroups = 1'b0;

    localparam logic [7:0] LineGroupsReset = 8'd19;

    // Special characters
    localparam logic [7:0] CharPad = 8'h3D;
    localparam logic [7:0] CharCr  = 8'h0D;
    localparam logic [7:0] CharLf  = 8'h0A;

    // Character slots inside one group word
    localparam logic [2:0] SlotThird = 3'd2;
    localparam logic [2:0] SlotFourth = 3'd3;
    localparam logic [2:0] SlotCr    = 3'd4;
    localparam logic [2:0] SlotLf    = 3'd5;

    // Pad counts
    localparam logic [1:0] PadNone = 2'd0;
    localparam logic [1:0] PadOne  = 2'd1;
    localparam logic [1:0] PadTwo  = 2'd2;

    // Queue between front and back
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
    localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

    // One group word: four sextets, pad count, line break and message end
    typedef struct packed {
        logic [3:0][5:0] sextets;
        logic [1:0]      pad_count;
        logic            crlf;
        logic            eom;
    } cmd_t;

    // Map a sextet to its base64 character
    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] w;
        begin
            w = {2'b00, s};
            if (s inside {[6'd0:6'd25]}) begin
                b64_char = w + 8'h41;
            end else if (s inside {[6'd26:6'd51]}) begin
                b64_char = w + 8'h47;   // 'a' - 26
            end else if (s inside {[6'd52:6'd61]}) begin
                b64_char = w - 8'h04;   // '0' - 52
            end else if (s == 6'd62) begin
                b64_char = 8'h2B;
            end else begin
                b64_char = 8'h2F;
            end
        end
    endfunction

endpackage

### design/b64e_front.sv
// Front end: collects bytes into groups and issues one group word per output group.
module b64e_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [7:0]          line_groups,
    input  logic                fifo_full,
    output logic                push,
    output b64e_pkg::cmd_t      cmd
);

    logic [7:0] pend0_reg, pend0_next;
    logic [7:0] pend1_reg, pend1_next;
    logic [1:0] pcnt_reg, pcnt_next;
    logic [7:0] groups_reg, groups_next;
    logic [7:0] groups_inc;
    logic       accept;

    assign in_ready   = !fifo_full;
    assign accept     = in_valid && in_ready;
    assign groups_inc = groups_reg + 8'd1;

    always_comb
    begin
        cmd         = '0;
        push        = 1'b0;
        pend0_next  = pend0_reg;
        pend1_next  = pend1_reg;
        pcnt_next   = pcnt_reg;
        groups_next = groups_reg;
        if (accept)
        begin
            if (pcnt_reg == 2'd2)
            begin
                // full group: two held bytes plus this one
                cmd.sextets[0] = pend0_reg[7:2];
                cmd.sextets[1] = {pend0_reg[1:0], pend1_reg[7:4]};
                cmd.sextets[2] = {pend1_reg[3:0], data_byte[7:6]};
                cmd.sextets[3] = data_byte[5:0];
                cmd.pad_count  = b64e_pkg::PadNone;
                cmd.crlf       = (line_groups != 8'd0) && (groups_inc >= line_groups);
                groups_next    = cmd.crlf ? 8'd0 : groups_inc;
                pcnt_next      = 2'd0;
                push           = 1'b1;
            end
            else if (last_byte)
            begin
                if (pcnt_reg == 2'd0)
                begin
                    cmd.sextets[0] = data_byte[7:2];
                    cmd.sextets[1] = {data_byte[1:0], 4'b0000};
                    cmd.pad_count  = b64e_pkg::PadTwo;
                end
                else
                begin
                    cmd.sextets[0] = pend0_reg[7:2];
                    cmd.sextets[1] = {pend0_reg[1:0], data_byte[7:4]};
                    cmd.sextets[2] = {data_byte[3:0], 2'b00};
                    cmd.pad_count  = b64e_pkg::PadOne;
                end
                push = 1'b1;
            end
            else
            begin
                // hold the byte until the group fills
                if (pcnt_reg[0])
                    pend1_next = data_byte;
                else
                    pend0_next = data_byte;
                pcnt_next = pcnt_reg + 2'd1;
            end
            cmd.eom = last_byte;
            if (last_byte)
            begin
                pcnt_next   = 2'd0;
                groups_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg   <= 2'd0;
            groups_reg <= 8'd0;
        end
        else
        begin
            pcnt_reg   <= pcnt_next;
            groups_reg <= groups_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

    a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg != 2'd3)
        else $error("pending count out of range");

endmodule

### design/b64e_fifo.sv
// Short queue of group words between the front and back ends.
module b64e_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::cmd_t push_data,
    input  logic           pop,
    output b64e_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    b64e_pkg::cmd_t                        mem [b64e_pkg::FifoDepth];
    logic [b64e_pkg::FifoPtrW-1:0]         wptr_reg, wptr_next;
    logic [b64e_pkg::FifoPtrW-1:0]         rptr_reg, rptr_next;
    logic [b64e_pkg::FifoCntW-1:0]         cnt_reg, cnt_next;

    localparam logic [b64e_pkg::FifoCntW-1:0] CntFull = b64e_pkg::FifoCntW'(b64e_pkg::FifoDepth);
    localparam logic [b64e_pkg::FifoCntW-1:0] CntOne  = b64e_pkg::FifoCntW'(1);
    localparam logic [b64e_pkg::FifoPtrW-1:0] PtrOne  = b64e_pkg::FifoPtrW'(1);

    assign full  = (cnt_reg == CntFull);
    assign empty = (cnt_reg == '0);
    assign head  = mem[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + PtrOne : wptr_reg;
        rptr_next = pop ? rptr_reg + PtrOne : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + CntOne;
        else if (pop && !push)
            cnt_next = cnt_reg - CntOne;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

### design/b64e_back.sv
// Back end: expands group words into characters, one per cycle while the receiver takes them, into an output register.
module b64e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  b64e_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_char,
    output logic           last_char,
    output logic           end_of_message
);

    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       lastc_reg, lastc_next;
    logic       eom_reg, eom_next;
    logic [2:0] slot_reg, slot_next;
    logic       load;
    logic       final_slot;
    logic       is_pad;
    logic [7:0] sel_char;

    assign load       = !valid_reg || out_ready;
    assign final_slot = head.crlf ? (slot_reg == b64e_pkg::SlotLf)
                                  : (slot_reg == b64e_pkg::SlotFourth);
    assign is_pad     = ((slot_reg == b64e_pkg::SlotFourth) && (head.pad_count != b64e_pkg::PadNone))
                     || ((slot_reg == b64e_pkg::SlotThird) && (head.pad_count == b64e_pkg::PadTwo));

    always_comb
    begin
        case (slot_reg)
            b64e_pkg::SlotCr: sel_char = b64e_pkg::CharCr;
            b64e_pkg::SlotLf: sel_char = b64e_pkg::CharLf;
            default:          sel_char = is_pad ? b64e_pkg::CharPad
                                                : b64e_pkg::b64_char(head.sextets[slot_reg[1:0]]);
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        valid_next = valid_reg;
        char_next  = char_reg;
        lastc_next = lastc_reg;
        eom_next   = eom_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                char_next  = sel_char;
                lastc_next = final_slot;
                eom_next   = final_slot && head.eom;
                if (final_slot)
                begin
                    slot_next = 3'd0;
                    pop       = 1'b1;
                end
                else
                    slot_next = slot_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        lastc_reg <= lastc_next;
        eom_reg   <= eom_next;
    end

    assign out_valid      = valid_reg;
    assign out_char       = char_reg;
    assign last_char      = lastc_reg;
    assign end_of_message = eom_reg;

    a_eom_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && eom_reg |-> lastc_reg)
        else $error("message end off the final character");

    a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && (char_reg == b64e_pkg::CharCr)
        |=> valid_reg && (char_reg == b64e_pkg::CharLf))
        else $error("CR not followed by LF");

endmodule

### design/base64_line_wrapped_encoder.sv
// Top level of the base64 encoder with CR LF line wrapping.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte, last_byte) takes one message
//   byte per word; last_byte marks the final byte of a message. Output channel
//   (out_valid/out_ready, out_char, last_char, end_of_message) gives one ASCII
//   character per word. last_char flags the final character caused by an
//   input word, end_of_message the final character of the whole message.
//   line_groups (APB, address 0) sets four-character groups per line, 0 turns
//   wrapping off; reset value 19 gives 76-character lines.
// Path: the byte that completes a group pushes its group word into the queue,
//   and the back end then loads the group's first character into the output register.
// Throughput: input words are taken every cycle while the four-entry group
//   queue has room; the output register drains one character per cycle while
//   out_ready is high, and a line break adds the two characters CR LF.
// Reset: clears the pending byte count, line count, queue and output valid and
//   loads line_groups with 19.
// Stall: when out_ready is low the output register and queue hold; once the
//   queue fills, in_ready drops until the receiver takes characters again.
module base64_line_wrapped_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    // character output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_char,
    output logic                          last_char,
    output logic                          end_of_message,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [b64e_pkg::ApbAddrW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [7:0]     line_groups_reg, line_groups_next;
    logic           reg_hit;
    logic           cfg_write;
    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;
    b64e_pkg::cmd_t cmd;
    b64e_pkg::cmd_t head;

    // Register decode: word index is paddr[2], byte lanes ignored
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[b64e_pkg::ApbAddrW-1:2] == b64e_pkg::RegLineGroups);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? {24'd0, line_groups_reg} : 32'd0;

    always_comb
    begin
        line_groups_next = line_groups_reg;
        if (cfg_write && reg_hit)
            line_groups_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_groups_reg <= b64e_pkg::LineGroupsReset;
        else
            line_groups_reg <= line_groups_next;
    end

    // Front: group bytes, decide padding and line breaks
    b64e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .line_groups (line_groups_reg),
        .fifo_full   (fifo_full),
        .push        (push),
        .cmd         (cmd)
    );

    // Queue: decouple byte intake from character output
    b64e_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // Back: emit characters of the head group word
    b64e_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (fifo_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .last_char      (last_char),
        .end_of_message (end_of_message)
    );

endmodule

### verif/tb_base64_line_wrapped_encoder.sv
// Self-checking testbench for the base64 encoder with CR LF line wrapping.
module tb_base64_line_wrapped_encoder;

    localparam int unsigned CycleLimit    = 1_000_000;
    localparam int unsigned DrainCycles   = 12;   // covers bytes still in flight that emit nothing
    localparam int unsigned HoldOffCycles = 300;  // long receiver stall, far beyond the group queue
    localparam int unsigned MaxReports    = 40;

    // byte address of line_groups: register index times four
    localparam logic [b64e_pkg::ApbAddrW-1:0] LineGroupsAddr = {b64e_pkg::RegLineGroups, 2'b00};

    // One expected output word: character plus its two end flags
    typedef struct packed {
        logic [7:0] ch;
        logic       ends_step;
        logic       ends_msg;
    } enc_char_t;

    // Predicts the character stream and checks each word taken from the block
    class b64_scoreboard;
        string        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        logic [7:0]   line_groups = b64e_pkg::LineGroupsReset;
        logic [7:0]   held [2];
        int unsigned  held_cnt = 0;
        logic [7:0]   groups_on_line = 8'd0;
        enc_char_t    expected_chars [$];
        int unsigned  errors = 0;
        int unsigned  bytes_in = 0;
        int unsigned  messages = 0;
        int unsigned  chars_checked = 0;
        int unsigned  line_breaks = 0;

        function logic [7:0] to_char(logic [5:0] s);
            return alphabet[s];
        endfunction

        function void load_line_groups(logic [7:0] v);
            line_groups = v;
        endfunction

        // Note one accepted byte and queue the characters it causes
        function void note_byte(logic [7:0] b, logic fin);
            logic [7:0] chars [$];
            logic [7:0] b0;
            logic [7:0] b1;
            enc_char_t  c;
            b0 = held[0];
            b1 = held[1];
            bytes_in++;
            if (held_cnt == 2) begin
                chars.push_back(to_char(b0[7:2]));
                chars.push_back(to_char({b0[1:0], b1[7:4]}));
                chars.push_back(to_char({b1[3:0], b[7:6]}));
                chars.push_back(to_char(b[5:0]));
                groups_on_line = groups_on_line + 8'd1;
                if (line_groups != 8'd0 && groups_on_line >= line_groups) begin
                    chars.push_back(b64e_pkg::CharCr);
                    chars.push_back(b64e_pkg::CharLf);
                    groups_on_line = 8'd0;
                    line_breaks++;
                end
                held_cnt = 0;
                held[0] = 8'd0;
                held[1] = 8'd0;
            end else if (fin) begin
                if (held_cnt == 0) begin
                    chars.push_back(to_char(b[7:2]));
                    chars.push_back(to_char({b[1:0], 4'b0000}));
                    chars.push_back(b64e_pkg::CharPad);
                    chars.push_back(b64e_pkg::CharPad);
                end else begin
                    chars.push_back(to_char(b0[7:2]));
                    chars.push_back(to_char({b0[1:0], b[7:4]}));
                    chars.push_back(to_char({b[3:0], 2'b00}));
                    chars.push_back(b64e_pkg::CharPad);
                end
            end else begin
                held[held_cnt] = b;
                held_cnt++;
            end
            if (fin) begin
                held_cnt = 0;
                held[0] = 8'd0;
                held[1] = 8'd0;
                groups_on_line = 8'd0;
                messages++;
            end
            foreach (chars[i]) begin
                c.ch        = chars[i];
                c.ends_step = (i == chars.size() - 1);
                c.ends_msg  = (i == chars.size() - 1) && fin;
                expected_chars.push_back(c);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MaxReports)
                $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // Compare one accepted character against the oldest expectation
        task check_char(logic [7:0] ch, logic ends_step, logic ends_msg);
            enc_char_t e;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", ch));
                return;
            end
            e = expected_chars.pop_front();
            chars_checked++;
            if (ch !== e.ch)
                report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", ch, e.ch));
            if (ends_step !== e.ends_step)
                report_mismatch($sformatf("last_char %b, want %b on 0x%02h",
                                          ends_step, e.ends_step, e.ch));
            if (ends_msg !== e.ends_msg)
                report_mismatch($sformatf("end_of_message %b, want %b on 0x%02h",
                                          ends_msg, e.ends_msg, e.ch));
        endtask
    endclass

    // Block inputs, all known from time zero
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [7:0]                    data_byte = 8'd0;
    logic                          last_byte = 1'b0;
    logic                          out_ready = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [b64e_pkg::ApbAddrW-1:0] paddr     = '0;
    logic [31:0]                   pwdata    = 32'd0;

    logic                in_ready;
    logic                out_valid;
    logic [7:0]          out_char;
    logic                last_char;
    logic                end_of_message;
    logic [31:0]         prdata;
    logic                pready;

    b64_scoreboard       sb;
    bit                  tx_gaps_on = 1'b1;
    bit                  rx_gaps_on = 1'b1;
    int unsigned         holds_asked = 0;
    int unsigned         holds_served = 0;
    int unsigned         rx_stall = 0;
    int unsigned         cycles = 0;
    int unsigned         settings_seen [$];

    base64_line_wrapped_encoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .last_char      (last_char),
        .end_of_message (end_of_message),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 clk = ~clk;

    // Gap length: mostly none, often a few cycles, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Sample both handshakes at the edge, input side first, so a byte is
    // always noted before any character it causes can be checked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_byte(data_byte, last_byte);
            if (out_valid && out_ready)
                sb.check_char(out_char, last_char, end_of_message);
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // asks for one. The hold-off is counted here, independent of the sender.
    always @(posedge clk) begin
        if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            rx_stall = HoldOffCycles;
        end else if (rx_stall == 0 && rx_gaps_on && $urandom_range(0, 3) == 0) begin
            rx_stall = gap_len();
        end
        if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycles, sb.expected_chars.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one byte word; hold valid and payload until the block takes it.
    // Valid drops only when a gap is inserted, never in the step it rises.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        gap = tx_gaps_on ? gap_len() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid, let the last byte get noted, wait until every expected
    // character has come out, then give bytes that emit nothing time to settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_chars.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Write line_groups: setup cycle, then access until pready
    task automatic set_line_groups(input logic [7:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LineGroupsAddr;
        pwdata  <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.load_line_groups(v);
        settings_seen.push_back(32'(v));
    endtask

    // Whole messages of random bytes; mostly short, a few spanning lines
    task automatic run_messages(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
            for (int unsigned i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One group per line: one-byte, two-byte and three-byte messages with
        // all-zero and all-one bytes; the last one completes a group on the
        // last byte, so CR LF follows and the LF ends the message.
        set_line_groups(8'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_idle();

        // Two groups on a line of three, then a byte left pending
        set_line_groups(8'd3);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h55, 1'b0);
        wait_idle();

        // Lower the limit to the count mid-line: the next group breaks
        set_line_groups(8'd2);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();

        // Random traffic across several line lengths, extremes included
        set_line_groups(8'd0);
        run_messages(40);
        wait_idle();
        set_line_groups(8'd255);
        run_messages(40);
        wait_idle();
        set_line_groups(b64e_pkg::LineGroupsReset);
        run_messages(30);
        wait_idle();

        // Short lines, no idling on either side, and a long receiver hold-off
        // while bytes keep coming, so the group queue fills and stalls input
        set_line_groups(8'($urandom_range(1, 4)));
        tx_gaps_on  = 1'b0;
        rx_gaps_on  = 1'b0;
        holds_asked = holds_asked + 1;
        run_messages(40);
        wait_idle();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;

        set_line_groups(8'($urandom_range(0, 255)));
        run_messages(40);
        wait_idle();

        // Wrapping off for eight groups, then switch wrapping on with a limit
        // below the count mid-message: the next group breaks at once
        set_line_groups(8'd0);
        for (int unsigned i = 0; i < 24; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        set_line_groups(8'd4);
        for (int unsigned i = 0; i < 6; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();

        set_line_groups(8'd2);
        run_messages(40);
        wait_idle();

        $display("covered %0d bytes in %0d messages, %0d characters checked, %0d line breaks",
                 sb.bytes_in, sb.messages, sb.chars_checked, sb.line_breaks);
        $display("line_groups settings used: %p", settings_seen);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_fifo.sv
design/b64e_back.sv
design/base64_line_wrapped_encoder.sv
verif/tb_base64_line_wrapped_encoder.sv
